// ===== src/lmlp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the linear MLP forward-pass engine.
package lmlp_pkg;

    localparam int LAYERS_DEF       = 7;
    localparam int NODES_DEF        = 8;
    localparam int INPUTS_DEF       = 2;
    localparam int WEIGHT_DEPTH_DEF = 512;

    localparam int DATA_W = 32;
    localparam int IDX_W  = 9;
    localparam int PROD_W = 64;
    // accumulator covers 64 rounded products of up to 2^46 each
    localparam int ACC_W  = 56;
    localparam int WIDE_W = 66;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    localparam logic signed [WIDE_W-1:0] SAT_MAX = 66'sd2147483647;
    localparam logic signed [WIDE_W-1:0] SAT_MIN = -66'sd2147483648;
    // 2^32 (the +1 term in Q32.32) plus 2^16 rounding before the halving shift
    localparam logic signed [WIDE_W-1:0] FX_PLUS_K = 66'sh1_0001_0000;
    localparam logic signed [WIDE_W-1:0] FX_RND    = 66'sh1_0000;

    typedef struct packed {
        logic                     op;
        logic [IDX_W-1:0]         weight_index;
        logic signed [DATA_W-1:0] weight_value;
        logic signed [DATA_W-1:0] in_first;
        logic signed [DATA_W-1:0] in_second;
    } in_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] net_out;
        logic signed [DATA_W-1:0] fx_plus;
        logic signed [DATA_W-1:0] fx_minus;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ISSUE,
        ST_DRAIN,
        ST_FX
    } state_t;

    typedef struct packed {
        logic step;
        logic last;
        logic fin;
        logic zero_w;
        logic fx;
    } mac_cmd_t;

    typedef struct packed {
        logic busy;
        logic wb_valid;
        logic done;
    } mac_stat_t;

    function automatic int bank_size(input int nodes, input int inputs);
        return (nodes > inputs) ? nodes : inputs;
    endfunction

    function automatic int weight_total(input int layers, input int nodes, input int inputs);
        return inputs * nodes + (layers - 2) * nodes * nodes + nodes;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
        logic signed [DATA_W-1:0] r;
        if (x > SAT_MAX)
            r = SAT_MAX[DATA_W-1:0];
        else if (x < SAT_MIN)
            r = SAT_MIN[DATA_W-1:0];
        else
            r = x[DATA_W-1:0];
        return r;
    endfunction

endpackage

// ===== src/lmlp_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
module lmlp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/lmlp_mac.sv =====
`timescale 1ns / 1ps
// Shared multiply-accumulate pipeline with neuron write-back and fx post-processing.
module lmlp_mac import lmlp_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  mac_cmd_t                 mac_cmd,
    input  logic signed [DATA_W-1:0] w_rdata,
    input  logic signed [DATA_W-1:0] a_rdata,
    output mac_stat_t                mac_stat,
    output logic signed [DATA_W-1:0] wb_data,
    output out_word_t                res_word
);

    logic s1_v_reg, s1_last_reg, s1_fin_reg, s1_zw_reg, fx1_v_reg;
    logic s2_v_reg, s2_last_reg, s2_fin_reg, fx2_v_reg;
    logic wb_v_reg, wb_fin_reg, fx3_v_reg, res_v_reg;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  sum_reg;
    logic signed [DATA_W-1:0] y_reg;
    logic signed [WIDE_W-1:0] plus_reg;
    logic signed [WIDE_W-1:0] minus_reg;
    out_word_t                res_reg;

    logic signed [DATA_W-1:0] mul_a;
    logic signed [DATA_W-1:0] mul_b;
    logic signed [47:0]       rp;
    logic signed [WIDE_W-1:0] sq_x;
    logic signed [WIDE_W-1:0] ys_x;

    always_comb
    begin
        mul_a = fx1_v_reg ? y_reg : (s1_zw_reg ? '0 : w_rdata);
        mul_b = fx1_v_reg ? y_reg : a_rdata;
    end

    // floor((p + 2^15) / 2^16) == (p >>> 16) + p[15]
    assign rp       = prod_reg[PROD_W-1:16];
    assign acc_next = acc_reg + {{(ACC_W-48){rp[47]}}, rp}
                      + {{(ACC_W-1){1'b0}}, prod_reg[15]};

    assign sq_x = {{(WIDE_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign ys_x = {{(WIDE_W-DATA_W-16){y_reg[DATA_W-1]}}, y_reg, 16'b0};

    assign wb_data = sat32({{(WIDE_W-ACC_W){sum_reg[ACC_W-1]}}, sum_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg    <= 1'b0;
            s1_last_reg <= 1'b0;
            s1_fin_reg  <= 1'b0;
            s1_zw_reg   <= 1'b0;
            fx1_v_reg   <= 1'b0;
            s2_v_reg    <= 1'b0;
            s2_last_reg <= 1'b0;
            s2_fin_reg  <= 1'b0;
            fx2_v_reg   <= 1'b0;
            wb_v_reg    <= 1'b0;
            wb_fin_reg  <= 1'b0;
            fx3_v_reg   <= 1'b0;
            res_v_reg   <= 1'b0;
            acc_reg     <= '0;
        end
        else
        begin
            s1_v_reg    <= mac_cmd.step;
            s1_last_reg <= mac_cmd.last;
            s1_fin_reg  <= mac_cmd.fin;
            s1_zw_reg   <= mac_cmd.zero_w;
            fx1_v_reg   <= mac_cmd.fx;
            s2_v_reg    <= s1_v_reg;
            s2_last_reg <= s1_last_reg;
            s2_fin_reg  <= s1_fin_reg;
            fx2_v_reg   <= fx1_v_reg;
            wb_v_reg    <= s2_v_reg && s2_last_reg;
            wb_fin_reg  <= s2_v_reg && s2_last_reg && s2_fin_reg;
            fx3_v_reg   <= fx2_v_reg;
            res_v_reg   <= fx3_v_reg;
            if (s2_v_reg)
            begin
                acc_reg <= s2_last_reg ? '0 : acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        if (s2_v_reg && s2_last_reg)
        begin
            sum_reg <= acc_next;
        end
        if (wb_fin_reg)
        begin
            y_reg <= wb_data;
        end
        if (fx2_v_reg)
        begin
            plus_reg  <= sq_x + ys_x + FX_PLUS_K;
            minus_reg <= sq_x - ys_x + FX_RND;
        end
        if (fx3_v_reg)
        begin
            res_reg.net_out  <= y_reg;
            res_reg.fx_plus  <= sat32(plus_reg >>> 17);
            res_reg.fx_minus <= sat32(minus_reg >>> 17);
        end
    end

    assign mac_stat.busy     = s1_v_reg || s2_v_reg || wb_v_reg;
    assign mac_stat.wb_valid = wb_v_reg;
    assign mac_stat.done     = res_v_reg;
    assign res_word          = res_reg;

endmodule

// ===== src/lmlp_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer: input load, layer/neuron/weight counters and activation write-back.
module lmlp_ctrl import lmlp_pkg::*; #(
    parameter int LAYERS       = LAYERS_DEF,
    parameter int NODES        = NODES_DEF,
    parameter int INPUTS       = INPUTS_DEF,
    parameter int WEIGHT_DEPTH = WEIGHT_DEPTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  in_word_t                  cmd_word,
    output logic                      busy,
    output mac_cmd_t                  mac_cmd,
    input  mac_stat_t                 mac_stat,
    input  logic signed [DATA_W-1:0]  wb_data,
    output logic [$clog2(WEIGHT_DEPTH)-1:0] w_raddr,
    output logic [$clog2(2*bank_size(NODES, INPUTS))-1:0] a_raddr,
    output logic                      a_we,
    output logic [$clog2(2*bank_size(NODES, INPUTS))-1:0] a_waddr,
    output logic signed [DATA_W-1:0]  a_wdata
);

    localparam int BANK   = bank_size(NODES, INPUTS);
    localparam int ACT_AW = $clog2(2 * BANK);
    localparam int AW     = $clog2(WEIGHT_DEPTH);
    localparam int TOTAL  = weight_total(LAYERS, NODES, INPUTS);
    localparam int CNT_W  = $clog2(((TOTAL > WEIGHT_DEPTH) ? TOTAL : WEIGHT_DEPTH) + 1);
    localparam int KW     = (BANK > 1) ? $clog2(BANK) : 1;
    localparam int NW     = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int LW     = $clog2(LAYERS);

    localparam logic [KW-1:0]     K_LAST_IN  = KW'(INPUTS - 1);
    localparam logic [KW-1:0]     K_LAST_HID = KW'(NODES - 1);
    localparam logic [NW-1:0]     N_LAST     = NW'(NODES - 1);
    localparam logic [LW-1:0]     L_LAST     = LW'(LAYERS - 1);
    localparam logic [ACT_AW-1:0] BANK_BASE  = ACT_AW'(BANK);
    localparam logic [CNT_W-1:0]  W_END      = CNT_W'(WEIGHT_DEPTH);
    localparam logic [CNT_W-1:0]  W_TOTAL    = CNT_W'(TOTAL);

    state_t state_reg, state_next;

    logic [LW-1:0]    layer_reg, layer_next;
    logic [NW-1:0]    neuron_reg, neuron_next;
    logic [KW-1:0]    k_reg, k_next;
    logic [CNT_W-1:0] widx_reg, widx_next;
    logic             bank_reg, bank_next;
    logic [NW-1:0]    wr_n_reg, wr_n_next;
    logic signed [DATA_W-1:0] first_reg, first_next;
    logic signed [DATA_W-1:0] second_reg, second_next;

    logic k_last, n_last, last_layer, load_last, eval_start;

    always_comb
    begin
        last_layer = (layer_reg == L_LAST);
        k_last     = (k_reg == ((layer_reg == '0) ? K_LAST_IN : K_LAST_HID));
        n_last     = last_layer || (neuron_reg == N_LAST);
        load_last  = (k_reg == K_LAST_IN);
        eval_start = start && (cmd_word.op == OP_EVAL);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (eval_start)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (load_last)
                    state_next = ST_ISSUE;
            end
            ST_ISSUE:
            begin
                if (k_last && n_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                // next layer reads what this one wrote: wait for write-back
                if (!mac_stat.busy)
                    state_next = last_layer ? ST_FX : ST_ISSUE;
            end
            ST_FX:
            begin
                if (mac_stat.done)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // counters and captured inputs
    always_comb
    begin
        layer_next  = layer_reg;
        neuron_next = neuron_reg;
        k_next      = k_reg;
        widx_next   = widx_reg;
        bank_next   = bank_reg;
        wr_n_next   = wr_n_reg;
        first_next  = first_reg;
        second_next = second_reg;
        if (mac_stat.wb_valid)
            wr_n_next = wr_n_reg + NW'(1);
        case (state_reg)
            ST_IDLE:
            begin
                if (eval_start)
                begin
                    first_next  = cmd_word.in_first;
                    second_next = cmd_word.in_second;
                    k_next      = '0;
                    bank_next   = 1'b0;
                end
            end
            ST_LOAD:
            begin
                k_next = k_reg + KW'(1);
                if (load_last)
                begin
                    k_next      = '0;
                    layer_next  = '0;
                    neuron_next = '0;
                    widx_next   = '0;
                    wr_n_next   = '0;
                end
            end
            ST_ISSUE:
            begin
                widx_next = widx_reg + CNT_W'(1);
                if (k_last)
                begin
                    k_next      = '0;
                    neuron_next = n_last ? '0 : neuron_reg + NW'(1);
                end
                else
                begin
                    k_next = k_reg + KW'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!mac_stat.busy && !last_layer)
                begin
                    layer_next = layer_reg + LW'(1);
                    bank_next  = !bank_reg;
                    wr_n_next  = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // outputs
    always_comb
    begin
        busy           = (state_reg != ST_IDLE);
        mac_cmd.step   = (state_reg == ST_ISSUE);
        mac_cmd.last   = k_last;
        mac_cmd.fin    = k_last && last_layer;
        mac_cmd.zero_w = (widx_reg >= W_END);
        mac_cmd.fx     = (state_reg == ST_DRAIN) && !mac_stat.busy && last_layer;
        w_raddr        = widx_reg[AW-1:0];
        a_raddr        = (bank_reg ? BANK_BASE : '0) + ACT_AW'(k_reg);
        if (state_reg == ST_LOAD)
        begin
            a_we    = 1'b1;
            a_waddr = ACT_AW'(k_reg);
            if (k_reg == '0)
                a_wdata = first_reg;
            else if (k_reg == KW'(1))
                a_wdata = second_reg;
            else
                a_wdata = '0;
        end
        else
        begin
            a_we    = mac_stat.wb_valid;
            a_waddr = (bank_reg ? '0 : BANK_BASE) + ACT_AW'(wr_n_reg);
            a_wdata = wb_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            layer_reg  <= '0;
            neuron_reg <= '0;
            k_reg      <= '0;
            widx_reg   <= '0;
            bank_reg   <= 1'b0;
            wr_n_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            layer_reg  <= layer_next;
            neuron_reg <= neuron_next;
            k_reg      <= k_next;
            widx_reg   <= widx_next;
            bank_reg   <= bank_next;
            wr_n_reg   <= wr_n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg  <= first_next;
        second_reg <= second_next;
    end

`ifndef SYNTH
    a_wb_in_layer: assert property (@(posedge clk) disable iff (!rst_n)
        mac_stat.wb_valid |-> (state_reg == ST_ISSUE || state_reg == ST_DRAIN))
        else $error("neuron write-back outside layer processing");

    a_done_in_fx: assert property (@(posedge clk) disable iff (!rst_n)
        mac_stat.done |-> (state_reg == ST_FX))
        else $error("result strobe outside fx phase");

    a_widx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ISSUE) |-> (widx_reg < W_TOTAL))
        else $error("weight index ran past the network");

    a_wr_n_range: assert property (@(posedge clk) disable iff (!rst_n)
        mac_stat.wb_valid |-> (wr_n_reg <= N_LAST))
        else $error("more neuron writes than neurons in a layer");
`endif

endmodule

// ===== src/linear_mlp_forward_pass.sv =====
`timescale 1ns / 1ps
// Top level of the linear MLP forward-pass engine: weight store, activation store, MAC, sequencer.
//
//   channel  | handshake              | word
//   ---------+------------------------+----------------------------------------
//   command  | start, busy (in idle)  | cmd_word: op, weight_index, weight_value,
//            |                        |           in_first, in_second
//   result   | res_strobe (1 cycle)   | res_word: net_out, fx_plus, fx_minus
//
// A weight write leaves busy low.
// An evaluation keeps busy high through the input load, one weight-store read and
// one shared multiply-accumulate per weight, a write-back drain at each layer end
// and the fx post-processing.
// res_strobe is high for one cycle and cannot be held off; busy drops after it.
// Reset clears control only; both stores hold garbage until written.
module linear_mlp_forward_pass import lmlp_pkg::*; #(
    parameter int LAYERS       = LAYERS_DEF,
    parameter int NODES        = NODES_DEF,
    parameter int INPUTS       = INPUTS_DEF,
    parameter int WEIGHT_DEPTH = WEIGHT_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_word_t  cmd_word,
    output logic      res_strobe,
    output out_word_t res_word
);

    localparam int BANK   = bank_size(NODES, INPUTS);
    localparam int ACT_AW = $clog2(2 * BANK);
    localparam int AW     = $clog2(WEIGHT_DEPTH);

    logic [AW+IDX_W-1:0]  idx_wide;
    logic                 w_we;
    logic [AW-1:0]        w_raddr;
    logic [DATA_W-1:0]    w_rdata;
    logic [ACT_AW-1:0]    a_raddr;
    logic [ACT_AW-1:0]    a_waddr;
    logic                 a_we;
    logic signed [DATA_W-1:0] a_wdata;
    logic [DATA_W-1:0]    a_rdata;
    logic signed [DATA_W-1:0] wb_data;
    mac_cmd_t             mac_cmd;
    mac_stat_t            mac_stat;

    // writes beyond the store are dropped
    assign idx_wide = {{AW{1'b0}}, cmd_word.weight_index};
    assign w_we     = start && !busy && (cmd_word.op == OP_WRITE)
                      && (idx_wide < (AW+IDX_W)'(WEIGHT_DEPTH));

    lmlp_ram #(
        .WIDTH (DATA_W),
        .DEPTH (WEIGHT_DEPTH)
    ) u_weight_ram (
        .clk   (clk),
        .we    (w_we),
        .waddr (idx_wide[AW-1:0]),
        .wdata (cmd_word.weight_value),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    lmlp_ram #(
        .WIDTH (DATA_W),
        .DEPTH (2 * BANK)
    ) u_act_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    lmlp_ctrl #(
        .LAYERS       (LAYERS),
        .NODES        (NODES),
        .INPUTS       (INPUTS),
        .WEIGHT_DEPTH (WEIGHT_DEPTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .cmd_word (cmd_word),
        .busy     (busy),
        .mac_cmd  (mac_cmd),
        .mac_stat (mac_stat),
        .wb_data  (wb_data),
        .w_raddr  (w_raddr),
        .a_raddr  (a_raddr),
        .a_we     (a_we),
        .a_waddr  (a_waddr),
        .a_wdata  (a_wdata)
    );

    lmlp_mac u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .mac_cmd  (mac_cmd),
        .w_rdata  (w_rdata),
        .a_rdata  (a_rdata),
        .mac_stat (mac_stat),
        .wb_data  (wb_data),
        .res_word (res_word)
    );

    assign res_strobe = mac_stat.done;

endmodule
